@@ sv/spop_pkg.sv @@
// shared types and constants for the script push-opcode parser
package spop_pkg;

  // opcode byte boundaries
  localparam logic [7:0] OpZero       = 8'h00;
  localparam logic [7:0] OpLastDirect = 8'h4b;
  localparam logic [7:0] OpPushData1  = 8'h4c;
  localparam logic [7:0] OpPushData2  = 8'h4d;
  localparam logic [7:0] OpPushData4  = 8'h4e;
  localparam logic [7:0] OpInvalid    = 8'hff;

  // byte roles
  localparam logic [1:0] RoleOpcode  = 2'd0;
  localparam logic [1:0] RolePrefix  = 2'd1;
  localparam logic [1:0] RolePayload = 2'd2;
  localparam logic [1:0] RoleDiscard = 2'd3;

  // error codes
  localparam logic [1:0] ErrNone        = 2'd0;
  localparam logic [1:0] ErrLengthShort = 2'd1;
  localparam logic [1:0] ErrPayloadShort = 2'd2;
  localparam logic [1:0] ErrBadOpcode   = 2'd3;

  // entries in the queue between front and back
  localparam int QueueDepth = 2;

  typedef enum logic [1:0] {
    CLS_PLAIN,
    CLS_DIRECT,
    CLS_PREFIX,
    CLS_REJECT
  } byte_class_t;

  typedef struct packed {
    logic [7:0] script_byte;
    logic       end_of_script;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  byte_role;
    logic [7:0]  byte_value;
    logic        instruction_end;
    logic [31:0] push_length;
    logic [1:0]  error_code;
    logic        script_done;
  } out_item_t;

  // classified byte as it travels from front to back
  typedef struct packed {
    logic [7:0]  script_byte;
    logic        end_of_script;
    byte_class_t byte_class;
    logic [2:0]  length_bytes;
  } queue_entry_t;

endpackage

@@ sv/script_push_opcode_parser_core.sv @@
// top level of the script push-opcode parser
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+---------------------------
//   in_     | in        | in_valid / in_stall   | spop_pkg::in_item_t
//   out_    | out       | out_valid / out_stall | spop_pkg::out_item_t
//
// one item per cycle sustained while out_stall stays low, one result item per input item
// a result item is registered: its input item is written into the queue, then the back
// part pops it and loads its result register; out_stall can hold it in the queue meanwhile
// rst_n is synchronous, active low; it clears parse state and the queue
// in_stall rises only when the two-entry queue is full, so a stalled
// output keeps taking items until the queue fills behind it
module script_push_opcode_parser_core #(
  parameter int LENGTH_BITS = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  // input channel: one script byte per item
  input  logic                in_valid,
  output logic                in_stall,
  input  spop_pkg::in_item_t  in_item,
  // result channel: one labelled byte per item
  output logic                out_valid,
  input  logic                out_stall,
  output spop_pkg::out_item_t out_item
);

  // front to queue
  logic                   q_push;
  logic                   q_full;
  spop_pkg::queue_entry_t q_entry;

  // queue to back
  logic                   q_pop;
  logic                   q_head_valid;
  spop_pkg::queue_entry_t q_head;

  // classify each byte as it arrives; no state needed here
  spop_front u_front (
    .in_valid (in_valid),
    .in_item  (in_item),
    .in_stall (in_stall),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_entry  (q_entry)
  );

  // decouples the input handshake from output back-pressure
  spop_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_entry),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head       (q_head)
  );

  // phase tracking, length decode, payload count, error handling
  spop_back #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (q_head_valid),
    .head       (q_head),
    .pop        (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_item   (out_item)
  );

endmodule

@@ sv/spop_front.sv @@
// front part: accepts input items and classifies each byte
module spop_front (
  input  logic                  in_valid,
  input  spop_pkg::in_item_t    in_item,
  output logic                  in_stall,
  input  logic                  q_full,
  output logic                  q_push,
  output spop_pkg::queue_entry_t q_entry
);

  logic [7:0] b;

  assign b        = in_item.script_byte;
  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    q_entry.script_byte   = b;
    q_entry.end_of_script = in_item.end_of_script;
    q_entry.length_bytes  = 3'd0;
    if (b != spop_pkg::OpZero && b <= spop_pkg::OpLastDirect) begin
      q_entry.byte_class = spop_pkg::CLS_DIRECT;
    end else if (b == spop_pkg::OpPushData1) begin
      q_entry.byte_class   = spop_pkg::CLS_PREFIX;
      q_entry.length_bytes = 3'd1;
    end else if (b == spop_pkg::OpPushData2) begin
      q_entry.byte_class   = spop_pkg::CLS_PREFIX;
      q_entry.length_bytes = 3'd2;
    end else if (b == spop_pkg::OpPushData4) begin
      q_entry.byte_class   = spop_pkg::CLS_PREFIX;
      q_entry.length_bytes = 3'd4;
    end else if (b == spop_pkg::OpInvalid) begin
      q_entry.byte_class = spop_pkg::CLS_REJECT;
    end else begin
      q_entry.byte_class = spop_pkg::CLS_PLAIN;
    end
  end

endmodule

@@ sv/spop_queue.sv @@
// short fifo of classified bytes between front and back
module spop_queue (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  input  spop_pkg::queue_entry_t push_entry,
  output logic                   full,
  input  logic                   pop,
  output logic                   head_valid,
  output spop_pkg::queue_entry_t head
);

  localparam int PtrBits = (spop_pkg::QueueDepth > 1) ? $clog2(spop_pkg::QueueDepth) : 1;
  localparam int CntBits = $clog2(spop_pkg::QueueDepth + 1);
  localparam logic [CntBits-1:0] DepthCnt = CntBits'(spop_pkg::QueueDepth);
  localparam logic [PtrBits-1:0] LastPtr  = PtrBits'(spop_pkg::QueueDepth - 1);

  spop_pkg::queue_entry_t entries_r [spop_pkg::QueueDepth];
  logic [PtrBits-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PtrBits-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CntBits-1:0] count_r, count_nxt;

  assign full       = (count_r == DepthCnt);
  assign head_valid = (count_r != '0);
  assign head       = entries_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LastPtr) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LastPtr) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

@@ sv/spop_back.sv @@
// back part: parse state machine and registered result item
module spop_back #(
  parameter int LENGTH_BITS = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   head_valid,
  input  spop_pkg::queue_entry_t head,
  output logic                   pop,
  output logic                   out_valid,
  input  logic                   out_stall,
  output spop_pkg::out_item_t    out_item
);

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_LENGTH,
    PH_PAYLOAD
  } phase_t;

  localparam logic [32:0] LenMaxWide = (33'd1 << LENGTH_BITS) - 33'd1;
  localparam logic [31:0] LenMax     = LenMaxWide[31:0];

  phase_t                 phase_r, phase_nxt;
  logic [2:0]             len_left_r, len_left_nxt;
  logic [1:0]             len_pos_r, len_pos_nxt;
  logic [31:0]            len_acc_r, len_acc_nxt;
  logic [LENGTH_BITS-1:0] pay_left_r, pay_left_nxt;
  logic                   failed_r, failed_nxt;
  logic                   out_valid_r;
  spop_pkg::out_item_t    out_item_r, res;

  logic [31:0]            acc_raw;
  logic [31:0]            plen_sat;
  logic [2:0]             len_dec;
  logic [LENGTH_BITS-1:0] pay_dec;
  logic [7:0]             b;
  logic                   eos;

  assign pop       = head_valid && (!out_valid_r || !out_stall);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;
  assign b         = head.script_byte;
  assign eos       = head.end_of_script;

  // place the incoming length byte, little-endian
  always_comb begin
    case (len_pos_r)
      2'd0:    acc_raw = len_acc_r | {24'd0, b};
      2'd1:    acc_raw = len_acc_r | {16'd0, b, 8'd0};
      2'd2:    acc_raw = len_acc_r | {8'd0, b, 16'd0};
      default: acc_raw = len_acc_r | {b, 24'd0};
    endcase
    plen_sat = (acc_raw > LenMax) ? LenMax : acc_raw;
    len_dec  = len_left_r - 3'd1;
    pay_dec  = pay_left_r - 1'b1;
  end

  always_comb begin
    phase_nxt    = phase_r;
    len_left_nxt = len_left_r;
    len_pos_nxt  = len_pos_r;
    len_acc_nxt  = len_acc_r;
    pay_left_nxt = pay_left_r;
    failed_nxt   = failed_r;

    res.byte_role       = spop_pkg::RoleOpcode;
    res.byte_value      = b;
    res.instruction_end = 1'b0;
    res.push_length     = 32'd0;
    res.error_code      = spop_pkg::ErrNone;
    res.script_done     = eos;

    if (failed_r) begin
      res.byte_role = spop_pkg::RoleDiscard;
    end else begin
      unique case (phase_r)
        PH_LENGTH: begin
          res.byte_role   = spop_pkg::RolePrefix;
          res.push_length = plen_sat;
          len_pos_nxt     = len_pos_r + 2'd1;
          len_left_nxt    = len_dec;
          if (len_dec == 3'd0) begin
            len_acc_nxt  = plen_sat;
            pay_left_nxt = plen_sat[LENGTH_BITS-1:0];
            if (plen_sat == 32'd0) begin
              res.instruction_end = 1'b1;
              phase_nxt           = PH_IDLE;
            end else begin
              phase_nxt = PH_PAYLOAD;
              if (eos) begin
                res.error_code = spop_pkg::ErrPayloadShort;
              end
            end
          end else begin
            len_acc_nxt = acc_raw;
            if (eos) begin
              res.error_code = spop_pkg::ErrLengthShort;
            end
          end
        end
        PH_PAYLOAD: begin
          res.byte_role   = spop_pkg::RolePayload;
          res.push_length = len_acc_r;
          pay_left_nxt    = pay_dec;
          if (pay_dec == '0) begin
            res.instruction_end = 1'b1;
            phase_nxt           = PH_IDLE;
          end else if (eos) begin
            res.error_code = spop_pkg::ErrPayloadShort;
          end
        end
        PH_IDLE: begin
          unique case (head.byte_class)
            spop_pkg::CLS_DIRECT: begin
              res.byte_role   = spop_pkg::RolePrefix;
              res.push_length = {24'd0, b};
              len_acc_nxt     = {24'd0, b};
              pay_left_nxt    = LENGTH_BITS'(b);
              phase_nxt       = PH_PAYLOAD;
              if (eos) begin
                res.error_code = spop_pkg::ErrPayloadShort;
              end
            end
            spop_pkg::CLS_PREFIX: begin
              res.byte_role = spop_pkg::RolePrefix;
              len_left_nxt  = head.length_bytes;
              len_pos_nxt   = 2'd0;
              len_acc_nxt   = 32'd0;
              phase_nxt     = PH_LENGTH;
              if (eos) begin
                res.error_code = spop_pkg::ErrLengthShort;
              end
            end
            spop_pkg::CLS_REJECT: begin
              res.byte_role  = spop_pkg::RoleDiscard;
              res.error_code = spop_pkg::ErrBadOpcode;
              failed_nxt     = 1'b1;
            end
            default: begin
              res.instruction_end = 1'b1;
            end
          endcase
        end
        default: begin
          phase_nxt = PH_IDLE;
        end
      endcase
    end

    // end of script returns all parse state to its reset values
    if (eos) begin
      phase_nxt    = PH_IDLE;
      len_left_nxt = 3'd0;
      len_pos_nxt  = 2'd0;
      len_acc_nxt  = 32'd0;
      pay_left_nxt = '0;
      failed_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      len_left_r  <= 3'd0;
      len_pos_r   <= 2'd0;
      len_acc_r   <= 32'd0;
      pay_left_r  <= '0;
      failed_r    <= 1'b0;
      out_valid_r <= 1'b0;
      out_item_r  <= '0;
    end else begin
      if (pop) begin
        phase_r     <= phase_nxt;
        len_left_r  <= len_left_nxt;
        len_pos_r   <= len_pos_nxt;
        len_acc_r   <= len_acc_nxt;
        pay_left_r  <= pay_left_nxt;
        failed_r    <= failed_nxt;
        out_valid_r <= 1'b1;
        out_item_r  <= res;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

@@ dv/script_push_opcode_parser_core_tb.sv @@
// self-checking testbench for the script push-opcode parser core
module script_push_opcode_parser_core_tb;

  localparam int LENGTH_BITS = 32;
  // largest push length the block can report, wider than 32 bits so the compare cannot wrap
  localparam logic [32:0] LENGTH_MAX = (33'd1 << LENGTH_BITS) - 33'd1;

  typedef enum logic [1:0] {
    PARSE_IDLE,
    PARSE_LENGTH,
    PARSE_PAYLOAD
  } parse_phase_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  spop_pkg::in_item_t  in_item = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  spop_pkg::out_item_t out_item;

  // idle chances in percent, changed between phases
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  int fail_count = 0;
  int sent_items = 0;  // input items accepted so far

  // parser state as the testbench sees it
  parse_phase_t phase;
  logic [2:0]   len_bytes_left;
  logic [1:0]   len_byte_pos;
  logic [31:0]  len_acc;
  logic [31:0]  payload_left;
  logic         dead;

  spop_pkg::out_item_t labelled_bytes[$];  // predicted result items, oldest first
  spop_pkg::out_item_t oldest_label;
  logic [7:0] script_bytes[$];   // script waiting to be sent

  script_push_opcode_parser_core #(
    .LENGTH_BITS(LENGTH_BITS)
  ) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item)
  );

  always #4 clk = ~clk;

  // ---------------------------------------------------------------------------
  // prediction
  // ---------------------------------------------------------------------------

  // everything goes back to idle at reset and after the final byte of a script
  function automatic void clear_parse_state();
    phase = PARSE_IDLE;
    len_bytes_left = '0;
    len_byte_pos = '0;
    len_acc = '0;
    payload_left = '0;
    dead = 1'b0;
  endfunction

  // lengths beyond what LENGTH_BITS can hold saturate
  function automatic logic [31:0] cap_length(input logic [31:0] v);
    return ({1'b0, v} > LENGTH_MAX) ? LENGTH_MAX[31:0] : v;
  endfunction

  // label one script byte and advance the parse state
  function automatic spop_pkg::out_item_t label_byte(input spop_pkg::in_item_t it);
    spop_pkg::out_item_t r;
    logic [7:0]          b;
    logic                eos;
    b = it.script_byte;
    eos = it.end_of_script;
    r = '0;
    r.byte_value = b;
    r.script_done = eos;
    r.byte_role = spop_pkg::RoleOpcode;
    r.error_code = spop_pkg::ErrNone;
    if (dead) begin
      // rest of a failed script is thrown away with no further error
      r.byte_role = spop_pkg::RoleDiscard;
    end else if (phase == PARSE_LENGTH) begin
      // little-endian length byte; push_length shows the partial length
      r.byte_role = spop_pkg::RolePrefix;
      len_acc = len_acc | (32'(b) << (8 * len_byte_pos));
      len_byte_pos = len_byte_pos + 2'd1;
      len_bytes_left = len_bytes_left - 3'd1;
      r.push_length = cap_length(len_acc);
      if (len_bytes_left == 3'd0) begin
        len_acc = r.push_length;
        payload_left = r.push_length;
        if (r.push_length == 32'd0) begin
          // zero-length push ends on its last length byte
          r.instruction_end = 1'b1;
          phase = PARSE_IDLE;
        end else begin
          phase = PARSE_PAYLOAD;
          if (eos) r.error_code = spop_pkg::ErrPayloadShort;
        end
      end else if (eos) begin
        r.error_code = spop_pkg::ErrLengthShort;
      end
    end else if (phase == PARSE_PAYLOAD) begin
      r.byte_role = spop_pkg::RolePayload;
      r.push_length = len_acc;
      payload_left = payload_left - 32'd1;
      if (payload_left == 32'd0) begin
        r.instruction_end = 1'b1;
        phase = PARSE_IDLE;
      end else if (eos) begin
        r.error_code = spop_pkg::ErrPayloadShort;
      end
    end else if (b != spop_pkg::OpZero && b <= spop_pkg::OpLastDirect) begin
      // direct push: the opcode itself is the length
      r.byte_role = spop_pkg::RolePrefix;
      r.push_length = cap_length(32'(b));
      len_acc = r.push_length;
      payload_left = r.push_length;
      phase = PARSE_PAYLOAD;
      if (eos) r.error_code = spop_pkg::ErrPayloadShort;
    end else if (b == spop_pkg::OpPushData1 || b == spop_pkg::OpPushData2 ||
                 b == spop_pkg::OpPushData4) begin
      r.byte_role = spop_pkg::RolePrefix;
      len_bytes_left = (b == spop_pkg::OpPushData1) ? 3'd1 :
                       (b == spop_pkg::OpPushData2) ? 3'd2 : 3'd4;
      len_byte_pos = '0;
      len_acc = '0;
      phase = PARSE_LENGTH;
      if (eos) r.error_code = spop_pkg::ErrLengthShort;
    end else if (b == spop_pkg::OpInvalid) begin
      // rejected opcode kills the script, no instruction end
      r.byte_role = spop_pkg::RoleDiscard;
      r.error_code = spop_pkg::ErrBadOpcode;
      dead = 1'b1;
    end else begin
      r.instruction_end = 1'b1;
    end
    if (eos) clear_parse_state();
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // driving
  // ---------------------------------------------------------------------------

  // send one byte; valid stays high between back-to-back items and only
  // drops when a gap is inserted
  task automatic send_byte(input logic [7:0] b, input logic eos);
    spop_pkg::in_item_t  it;
    spop_pkg::out_item_t r;
    it.script_byte = b;
    it.end_of_script = eos;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    // accepted at this edge
    r = label_byte(it);
    labelled_bytes.insert(labelled_bytes.size(), r);
    sent_items++;
  endtask

  // whole script from the queue, end flag on its last byte
  task automatic send_script();
    for (int i = 0; i < script_bytes.size(); i++)
      send_byte(script_bytes[i], i == script_bytes.size() - 1);
  endtask

  // random receiver stall, fresh every cycle
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // ---------------------------------------------------------------------------
  // checking
  // ---------------------------------------------------------------------------

  task automatic compare_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", field, want, got);
      fail_count++;
    end
  endtask

  // every accepted result item against the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (labelled_bytes.size() == 0) begin
        $error("result item with nothing expected: byte 0x%0h", out_item.byte_value);
        fail_count++;
      end else begin
        oldest_label = labelled_bytes.pop_front();
        compare_field("byte_role", oldest_label.byte_role, out_item.byte_role);
        compare_field("byte_value", oldest_label.byte_value, out_item.byte_value);
        compare_field("instruction_end", oldest_label.instruction_end,
                      out_item.instruction_end);
        compare_field("push_length", oldest_label.push_length, out_item.push_length);
        compare_field("error_code", oldest_label.error_code, out_item.error_code);
        compare_field("script_done", oldest_label.script_done, out_item.script_done);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // lowest opcode, first and last plain opcode above the push range
  task automatic test_plain_opcodes();
    script_bytes = '{spop_pkg::OpZero, 8'h4f, 8'hfe};
    send_script();
  endtask

  // one-byte direct push, then the largest direct push cut off at once
  task automatic test_direct_push();
    script_bytes = '{8'h01, 8'haa, spop_pkg::OpLastDirect};
    send_script();
  endtask

  // zero-length pushes with 1- and 2-byte lengths, then an all-ones 4-byte
  // length whose script ends right after it
  task automatic test_length_prefixed_push();
    script_bytes = '{spop_pkg::OpPushData1, 8'h00, spop_pkg::OpPushData2, 8'h00, 8'h00,
                     spop_pkg::OpPushData4, 8'hff, 8'hff, 8'hff, 8'hff};
    send_script();
  endtask

  // rejected opcode, then the rest of the script is discarded
  task automatic test_rejected_opcode();
    script_bytes = '{spop_pkg::OpInvalid, 8'h12, 8'h34};
    send_script();
  endtask

  // scripts ending inside a length field, on a prefix, inside a payload
  task automatic test_cut_short_scripts();
    script_bytes = '{spop_pkg::OpPushData2, 8'h01};
    send_script();
    script_bytes = '{spop_pkg::OpPushData4};
    send_script();
    script_bytes = '{spop_pkg::OpPushData1, 8'h02, 8'h55};
    send_script();
  endtask

  // append one byte to the script being built
  function automatic void add_script_byte(input logic [7:0] v);
    script_bytes.insert(script_bytes.size(), v);
  endfunction

  // mostly well-formed scripts with random content; some are cut short,
  // corrupted or plain noise
  task automatic build_random_script();
    int         n_instr;
    int         pick;
    int         len;
    int         nbytes;
    int         cut;
    logic [7:0] op;
    script_bytes.delete();
    n_instr = $urandom_range(1, 8);
    repeat (n_instr) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        op = 8'($urandom_range(8'h4f, 8'hfe));
        if ($urandom_range(7) == 0) op = spop_pkg::OpZero;
        add_script_byte(op);
      end else if (pick < 65) begin
        // direct push, now and then up to the largest one
        len = ($urandom_range(19) == 0) ? $urandom_range(1, 75) : $urandom_range(1, 8);
        add_script_byte(8'(len));
        repeat (len) add_script_byte(8'($urandom));
      end else if (pick < 97) begin
        // length-prefixed push, short payloads except for a rare long one
        len = ($urandom_range(39) == 0) ? $urandom_range(7, 300) : $urandom_range(0, 6);
        case ($urandom_range(2))
          0: nbytes = (len > 255) ? 2 : 1;
          1: nbytes = 2;
          default: nbytes = 4;
        endcase
        op = (nbytes == 1) ? spop_pkg::OpPushData1 :
             (nbytes == 2) ? spop_pkg::OpPushData2 : spop_pkg::OpPushData4;
        add_script_byte(op);
        for (int i = 0; i < nbytes; i++) add_script_byte(8'(len >> (8 * i)));
        repeat (len) add_script_byte(8'($urandom));
      end else begin
        add_script_byte(spop_pkg::OpInvalid);
      end
    end
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      // cut anywhere, usually inside a length or payload
      cut = $urandom_range(1, script_bytes.size());
      while (script_bytes.size() > cut) script_bytes.delete(script_bytes.size() - 1);
    end else if (pick < 14) begin
      // one random byte, may turn a length into something huge
      script_bytes[$urandom_range(0, script_bytes.size() - 1)] = 8'($urandom);
    end else if (pick < 18) begin
      script_bytes.delete();
      repeat ($urandom_range(1, 12)) add_script_byte(8'($urandom));
    end
  endtask

  task automatic test_random_scripts(input int send_pct, input int recv_pct,
                                     input int n_items);
    int goal;
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
    goal = sent_items + n_items;
    while (sent_items < goal) begin
      build_random_script();
      send_script();
    end
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------

  initial begin
    clear_parse_state();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // slow sender, heavily stalled receiver for the directed part and phase one
    send_idle_pct = 30;
    recv_stall_pct = 73;
    test_plain_opcodes();
    test_direct_push();
    test_length_prefixed_push();
    test_rejected_opcode();
    test_cut_short_scripts();
    test_random_scripts(30, 73, 410);
    test_random_scripts(73, 30, 410);
    test_random_scripts(0, 0, 410);
    in_valid <= 1'b0;

    // drain, then keep watching in case anything extra shows up
    while (labelled_bytes.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // hang guard, far beyond the slowest legal run
  initial begin
    #(8 * 600000);
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
